@@ rtl/core/pngunf_pkg.sv @@
// ----------------------------------------------------------------------------
// pngunf_pkg
// Shared types, constants and helper functions for the scanline unfilter.
// ----------------------------------------------------------------------------
package pngunf_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int CMP_W     = COL_W + 1;
   localparam int WIDTH_W   = 13;
   localparam int HEIGHT_W  = 16;
   localparam int PIX_W     = 32;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HAS_ALPHA    = 2'd2;

   // filter types
   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;

   // byte-in-pixel codes for the filter byte at row start and the first channel byte
   localparam logic [2:0] BIP_FILTER = 3'd0;
   localparam logic [2:0] BIP_FIRST  = 3'd1;

   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [WIDTH_W-1:0]  image_width;
      logic [HEIGHT_W-1:0] image_height;
      logic                has_alpha;
   } cfg_type;

   // one accepted byte with its decoded position, handed to reconstruction
   typedef struct packed {
      logic              is_filter;
      logic [2:0]        filter;
      logic [1:0]        chan;
      logic              col_nz;
      logic              row_nz;
      logic              last_chan;
      logic              row_end;
      logic              image_end;
      logic              has_alpha;
      logic [COL_W-1:0]  col;
      logic [BYTE_W-1:0] data;
   } item_type;

   // channel 0 (red) sits in the top byte
   function automatic logic [BYTE_W-1:0] chan_of(input logic [PIX_W-1:0] word,
                                                 input logic [1:0] ch);
      logic [BYTE_W-1:0] res;
      case (ch)
         2'd0:    res = word[31:24];
         2'd1:    res = word[23:16];
         2'd2:    res = word[15:8];
         default: res = word[7:0];
      endcase
      return res;
   endfunction

   function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [BYTE_W-1:0] c);
      logic signed [10:0] p;
      logic signed [10:0] da;
      logic signed [10:0] db;
      logic signed [10:0] dc;
      logic [BYTE_W-1:0]  res;
      p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
      da = p - $signed({3'b000, a});
      db = p - $signed({3'b000, b});
      dc = p - $signed({3'b000, c});
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      // ties prefer left, then upper
      if (da <= db && da <= dc) res = a;
      else if (db <= dc)        res = b;
      else                      res = c;
      return res;
   endfunction

endpackage

@@ rtl/core/pngunf_ram.sv @@
// ----------------------------------------------------------------------------
// pngunf_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pngunf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pngunf_ctrl.sv @@
// ----------------------------------------------------------------------------
// pngunf_ctrl
// Byte sequencer: tracks filter byte, channel, column and row, issues the
// line store read and registers the decoded byte for reconstruction.
// ----------------------------------------------------------------------------
module pngunf_ctrl import pngunf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              accept,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              item_go,
   output logic              item_valid,
   output item_type          item,
   output logic [COL_W-1:0]  rd_addr
);

   logic [2:0]          bip_ff, bip_in;
   logic [2:0]          filter_ff, filter_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic                item_valid_ff;
   item_type            item_ff, item_in;

   logic [CMP_W-1:0]    eff_width;
   logic [HEIGHT_W:0]   eff_height;
   logic [COL_W-1:0]    col;
   logic [1:0]          chan;
   logic [1:0]          last_chan_idx;
   logic                is_last;
   logic                row_end;
   logic                image_end;

   always_comb begin
      if (cfg.image_width == '0) begin
         eff_width = CMP_W'(1);
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         eff_width = CMP_W'(MAX_WIDTH);
      end else begin
         eff_width = CMP_W'(cfg.image_width);
      end
      eff_height = (cfg.image_height == '0) ? (HEIGHT_W+1)'(1)
                                            : {1'b0, cfg.image_height};

      // column clamps to the last one if the count runs past the width
      if ({1'b0, col_ff} >= eff_width) begin
         col = COL_W'(eff_width - CMP_W'(1));
      end else begin
         col = col_ff;
      end
      chan          = 2'(bip_ff - 3'd1);
      last_chan_idx = cfg.has_alpha ? 2'd3 : 2'd2;
      is_last       = (chan >= last_chan_idx);
      row_end       = ({1'b0, col} + CMP_W'(1)) >= eff_width;
      image_end     = ({1'b0, row_ff} + (HEIGHT_W+1)'(1)) >= eff_height;

      bip_in    = bip_ff;
      filter_in = filter_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (bip_ff == BIP_FILTER) begin
            filter_in = (in_byte > 8'(FILT_PAETH)) ? FILT_NONE : in_byte[2:0];
            bip_in    = BIP_FIRST;
         end else if (!is_last) begin
            bip_in = bip_ff + 3'd1;
         end else if (row_end) begin
            col_in = '0;
            bip_in = BIP_FILTER;
            row_in = image_end ? '0 : row_ff + HEIGHT_W'(1);
         end else begin
            col_in = col + COL_W'(1);
            bip_in = BIP_FIRST;
         end
      end

      item_in.is_filter = (bip_ff == BIP_FILTER);
      item_in.filter    = filter_ff;
      item_in.chan      = chan;
      item_in.col_nz    = (col != '0);
      item_in.row_nz    = (row_ff != '0);
      item_in.last_chan = (bip_ff != BIP_FILTER) && is_last;
      item_in.row_end   = row_end;
      item_in.image_end = row_end && image_end;
      item_in.has_alpha = cfg.has_alpha;
      item_in.col       = col;
      item_in.data      = in_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bip_ff        <= BIP_FILTER;
         filter_ff     <= FILT_NONE;
         col_ff        <= '0;
         row_ff        <= '0;
         item_valid_ff <= 1'b0;
      end else begin
         bip_ff    <= bip_in;
         filter_ff <= filter_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         if (accept) begin
            item_valid_ff <= 1'b1;
         end else if (item_go) begin
            item_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;
   assign rd_addr    = col;

endmodule

@@ rtl/core/pngunf_recon.sv @@
// ----------------------------------------------------------------------------
// pngunf_recon
// Reconstruction stage: predicts each channel byte from left, upper and
// upper-left neighbours, assembles pixels, writes the line store and holds
// the output register.
// ----------------------------------------------------------------------------
module pngunf_recon import pngunf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  item_type          item,
   input  logic [PIX_W-1:0]  upper_data,
   output logic              item_go,
   output logic              wr_en,
   output logic [COL_W-1:0]  wr_addr,
   output logic [PIX_W-1:0]  wr_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [PIX_W-1:0]  rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   logic [PIX_W-1:0]  left_ff, left_in;
   logic [PIX_W-1:0]  upleft_ff, upleft_in;
   logic [23:0]       acc_ff, acc_in;
   logic              out_valid_ff;
   logic [PIX_W-1:0]  out_pixel_ff;
   logic              out_row_end_ff;
   logic              out_image_end_ff;

   logic [PIX_W-1:0]  upper;
   logic [BYTE_W-1:0] a, b, c;
   logic [BYTE_W:0]   sum_ab;
   logic [BYTE_W-1:0] pred;
   logic [BYTE_W-1:0] val;
   logic [PIX_W-1:0]  pixel;
   logic              emits;

   always_comb begin
      upper  = item.row_nz ? upper_data : '0;
      a      = item.col_nz ? chan_of(left_ff, item.chan) : '0;
      b      = chan_of(upper, item.chan);
      c      = item.col_nz ? chan_of(upleft_ff, item.chan) : '0;
      sum_ab = {1'b0, a} + {1'b0, b};
      case (item.filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = sum_ab[BYTE_W:1];
         FILT_PAETH: pred = paeth(a, b, c);
         default:    pred = '0;
      endcase
      val = item.data + pred;
      if (item.has_alpha) begin
         pixel = {acc_ff, val};
      end else begin
         pixel = {acc_ff[15:0], val, ALPHA_OPAQUE};
      end

      emits   = item.last_chan;
      // stall only when a pixel is due and the output register is still full
      item_go = item_valid && (!emits || !out_valid_ff || rsp_tready);

      left_in   = left_ff;
      upleft_in = upleft_ff;
      acc_in    = acc_ff;
      if (item_go) begin
         if (item.is_filter) begin
            left_in   = '0;
            upleft_in = '0;
            acc_in    = '0;
         end else if (!emits) begin
            acc_in = {acc_ff[15:0], val};
         end else begin
            acc_in    = '0;
            left_in   = item.row_end ? '0 : pixel;
            upleft_in = item.row_end ? '0 : upper;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         upleft_ff    <= '0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff   <= left_in;
         upleft_ff <= upleft_in;
         acc_ff    <= acc_in;
         if (item_go && emits) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_go && emits) begin
         out_pixel_ff     <= pixel;
         out_row_end_ff   <= item.row_end;
         out_image_end_ff <= item.image_end;
      end
   end

   assign wr_en      = item_go && emits;
   assign wr_addr    = item.col;
   assign wr_data    = pixel;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;
   assign rsp_tlast  = out_row_end_ff;
   assign rsp_tuser  = out_image_end_ff;

endmodule

@@ rtl/core/png_scanline_unfilter_top.sv @@
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top
// PNG scanline unfilter for 8-bit RGB/RGBA: one inflated byte per transfer
// in, one RGBA32 pixel per transfer out, previous row kept in a line store.
//
//   channel  direction  payload
//   req_     in         tdata[7:0] stream_byte
//   rsp_     out        tdata[31:0] pixel_rgba, tlast row_end, tuser image_end
//   csr_     in         index 0 image_width, 1 image_height, 2 has_alpha
//
// One byte is taken every cycle unless the output stalls; a pixel's last byte is
// registered beside one line store read stage, then in one output register.
// The line store is read in the cycle a byte is accepted and written when
// the pixel completes; a filter byte always separates two uses of one column.
// A stalled output holds the reconstruction stage and with it the input.
// Reset is synchronous; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top import pngunf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,   // [7:0] stream_byte
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PIX_W-1:0]     rsp_tdata,   // [31:0] pixel_rgba
   output logic                 rsp_tlast,
   output logic                 rsp_tuser,   // [0] image_end
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type          cfg_ff;
   logic             accept;
   logic             item_valid;
   logic             item_go;
   item_type         item;
   logic [COL_W-1:0] rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic             wr_en;
   logic [COL_W-1:0] wr_addr;
   logic [PIX_W-1:0] wr_data;

   assign csr_ready  = 1'b1;
   assign req_tready = !item_valid || item_go;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= WIDTH_W'(1);
         cfg_ff.image_height <= HEIGHT_W'(1);
         cfg_ff.has_alpha    <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_data[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: cfg_ff.image_height <= csr_data[HEIGHT_W-1:0];
            REG_HAS_ALPHA:    cfg_ff.has_alpha    <= csr_data[0];
            default: ;
         endcase
      end
   end

   pngunf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .in_byte    (req_tdata),
      .item_go    (item_go),
      .item_valid (item_valid),
      .item       (item),
      .rd_addr    (rd_addr)
   );

   pngunf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pngunf_recon u_recon (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .upper_data (rd_data),
      .item_go    (item_go),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ tb/sv/png_scanline_unfilter_top_tb.sv @@
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top_tb
// Self-checking bench for the scanline unfilter. A short table of hand-made
// bytes comes first: tiny images with known pixels, sub/avg/Paeth rows, an
// unknown filter type and register changes between rows. Random phases of
// small images follow. Every accepted byte runs through a local unfilter
// model, and each pixel transfer is compared with the oldest pending pixel.
// Source gaps and sink stalls vary per phase.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top_tb;
   import pngunf_pkg::*;

   localparam int RAND_PHASES    = 16;
   localparam int PHASE_BYTES    = 75;
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic             row_last;
      logic             img_last;
   } pixel_type;

   typedef enum logic [1:0] {
      ROW_BYTE, ROW_SET_WIDTH, ROW_SET_HEIGHT, ROW_SET_ALPHA
   } step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      logic [CSR_DAT_W-1:0] value;
      logic                 known;
      pixel_type            want;
   } dir_step_type;

   typedef enum logic [1:0] {
      PACE_FULL, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH
   } pace_type;

   // hand-made images; the pixel is typed in where it is obvious
   localparam dir_step_type DIR_STEPS [33] = '{
      // 1x1 rgba after reset, unknown filter type acts as none
      '{ROW_BYTE,       16'h00FF, 1'b0, '0},
      '{ROW_BYTE,       16'h0000, 1'b0, '0},
      '{ROW_BYTE,       16'h00FF, 1'b0, '0},
      '{ROW_BYTE,       16'h0080, 1'b0, '0},
      '{ROW_BYTE,       16'h007F, 1'b1, '{32'h00FF807F, 1'b1, 1'b1}},
      // 2x3 rgb: sub on the top row
      '{ROW_SET_WIDTH,  16'h0002, 1'b0, '0},
      '{ROW_SET_HEIGHT, 16'h0003, 1'b0, '0},
      '{ROW_SET_ALPHA,  16'h0000, 1'b0, '0},
      '{ROW_BYTE,       16'h0001, 1'b0, '0},
      '{ROW_BYTE,       16'h0010, 1'b0, '0},
      '{ROW_BYTE,       16'h0020, 1'b0, '0},
      '{ROW_BYTE,       16'h0030, 1'b1, '{32'h102030FF, 1'b0, 1'b0}},
      '{ROW_BYTE,       16'h00F0, 1'b0, '0},
      '{ROW_BYTE,       16'h00E0, 1'b0, '0},
      '{ROW_BYTE,       16'h00D1, 1'b1, '{32'h000001FF, 1'b1, 1'b0}},
      // paeth row, zero deltas give ties
      '{ROW_BYTE,       16'h0004, 1'b0, '0},
      '{ROW_BYTE,       16'h0005, 1'b0, '0},
      '{ROW_BYTE,       16'h0000, 1'b0, '0},
      '{ROW_BYTE,       16'h00FF, 1'b0, '0},
      '{ROW_BYTE,       16'h0000, 1'b0, '0},
      '{ROW_BYTE,       16'h0080, 1'b0, '0},
      '{ROW_BYTE,       16'h0001, 1'b0, '0},
      // mid-image: height zero ends the image on this row, switch to rgba
      '{ROW_SET_HEIGHT, 16'h0000, 1'b0, '0},
      '{ROW_SET_ALPHA,  16'h0001, 1'b0, '0},
      '{ROW_BYTE,       16'h0003, 1'b0, '0},
      '{ROW_BYTE,       16'h0040, 1'b0, '0},
      '{ROW_BYTE,       16'h0041, 1'b0, '0},
      '{ROW_BYTE,       16'h0042, 1'b0, '0},
      '{ROW_BYTE,       16'h0043, 1'b0, '0},
      '{ROW_BYTE,       16'h007F, 1'b0, '0},
      '{ROW_BYTE,       16'h0080, 1'b0, '0},
      '{ROW_BYTE,       16'h0081, 1'b0, '0},
      '{ROW_BYTE,       16'h00FF, 1'b0, '0}
   };

   localparam logic [BYTE_W-1:0] CORNER_BYTES [5] = '{8'h00, 8'h01, 8'h02, 8'h80, 8'hFF};

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata  = '0;   // [7:0] stream_byte
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [PIX_W-1:0]     rsp_tdata;         // [31:0] pixel_rgba
   logic                 rsp_tlast;
   logic                 rsp_tuser;         // [0] image_end
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_DAT_W-1:0] csr_data   = '0;

   png_scanline_unfilter_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // unfilter state, starting from reset values
   logic [WIDTH_W-1:0]  cfg_width   = WIDTH_W'(1);
   logic [HEIGHT_W-1:0] cfg_height  = HEIGHT_W'(1);
   logic                cfg_alpha   = 1'b1;
   logic [PIX_W-1:0]    line_mem [MAX_WIDTH];
   logic [PIX_W-1:0]    prev_px     = '0;
   logic [PIX_W-1:0]    prev_up_px  = '0;
   logic [23:0]         partial_rgb = '0;
   logic [2:0]          cur_filter  = FILT_NONE;
   logic [2:0]          byte_slot   = BIP_FILTER;
   int                  col_idx     = 0;
   int                  row_idx     = 0;

   pixel_type pending_px [$];

   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int errors         = 0;
   int bytes_sent     = 0;
   int px_checked     = 0;
   int rows_seen      = 0;
   int images_seen    = 0;
   int quiet_cycles   = 0;

   function automatic int eff_cols();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   // advances the unfilter state by one byte; returns 1 when a pixel completes
   function automatic bit unfilter_byte(input logic [BYTE_W-1:0] x, output pixel_type res);
      int               wid;
      int               col;
      int               ch;
      int               a;
      int               b;
      int               c;
      int               pred;
      int               pa;
      int               pb;
      int               pc;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] word;
      logic [7:0]       v;
      wid = eff_cols();
      res = '0;
      if (byte_slot == BIP_FILTER) begin
         cur_filter  = (x > FILT_PAETH) ? FILT_NONE : x[2:0];
         byte_slot   = BIP_FIRST;
         prev_px     = '0;
         prev_up_px  = '0;
         partial_rgb = '0;
         return 1'b0;
      end
      col = (col_idx >= wid) ? wid - 1 : col_idx;
      ch  = (int'(byte_slot) - 1) & 3;
      up  = (row_idx > 0) ? line_mem[col] : '0;
      a   = (col > 0) ? int'(prev_px[31 - 8*ch -: 8]) : 0;
      b   = int'(up[31 - 8*ch -: 8]);
      c   = (col > 0) ? int'(prev_up_px[31 - 8*ch -: 8]) : 0;
      case (cur_filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = (a + b) / 2;
         FILT_PAETH: begin
            pa = (b > c) ? b - c : c - b;
            pb = (a > c) ? a - c : c - a;
            pc = (a + b > 2*c) ? a + b - 2*c : 2*c - a - b;
            // ties go to left, then upper
            if (pa <= pb && pa <= pc) pred = a;
            else if (pb <= pc)        pred = b;
            else                      pred = c;
         end
         default:    pred = 0;
      endcase
      v = x + 8'(pred);
      if (ch < (cfg_alpha ? 3 : 2)) begin
         partial_rgb = {partial_rgb[15:0], v};
         byte_slot   = byte_slot + 3'd1;
         return 1'b0;
      end
      word = cfg_alpha ? {partial_rgb, v} : {partial_rgb[15:0], v, ALPHA_OPAQUE};
      line_mem[col] = word;
      prev_up_px    = up;
      prev_px       = word;
      partial_rgb   = '0;
      byte_slot     = BIP_FIRST;
      res.px        = word;
      res.row_last  = (col + 1 >= wid);
      res.img_last  = 1'b0;
      if (res.row_last) begin
         col_idx    = 0;
         byte_slot  = BIP_FILTER;
         prev_px    = '0;
         prev_up_px = '0;
         if (row_idx + 1 >= ((cfg_height == 0) ? 1 : int'(cfg_height))) begin
            res.img_last = 1'b1;
            row_idx      = 0;
         end else begin
            row_idx = row_idx + 1;
         end
      end else begin
         col_idx = col + 1;
      end
      return 1'b1;
   endfunction

   function automatic logic [CSR_DAT_W-1:0] rand_height();
      int r;
      r = $urandom_range(99);
      if (r < 8) return '0;
      if (r < 12) return 16'hFFFF;
      return CSR_DAT_W'($urandom_range(4, 1));
   endfunction

   task automatic set_pace(input pace_type p);
      src_idle_pct   = (p == PACE_SRC_GAPS) ? 60 : (p == PACE_BOTH) ? 24 : 0;
      sink_stall_pct = (p == PACE_SINK_STALLS) ? 60 : (p == PACE_BOTH) ? 24 : 0;
   endtask

   // all tasks below start and end right after a rising edge
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                            input pixel_type want);
      pixel_type res;
      bit        got;
      if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      // inputs only move at the rising edge, so the falling edge shows the transfer
      do @(negedge clock); while (!req_tready);
      got = unfilter_byte(b, res);
      if (got) pending_px = {pending_px, (typed ? want : res)};
      bytes_sent++;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
      // a filter byte may still sit in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (!csr_ready);
      case (idx)
         REG_IMAGE_WIDTH:  cfg_width  = val[WIDTH_W-1:0];
         REG_IMAGE_HEIGHT: cfg_height = val[HEIGHT_W-1:0];
         REG_HAS_ALPHA:    cfg_alpha  = val[0];
         default: ;
      endcase
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_row();
      int          n;
      logic [7:0]  b;
      n = eff_cols() * (cfg_alpha ? 4 : 3);
      b = ($urandom_range(99) < 85) ? 8'($urandom_range(4)) : 8'($urandom_range(255, 5));
      send_byte(b, 1'b0, '0);
      repeat (n) begin
         b = ($urandom_range(99) < 35) ? CORNER_BYTES[$urandom_range(4)]
                                       : 8'($urandom_range(255));
         send_byte(b, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   always @(negedge clock) begin
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_px.size() == 0) begin
            $display("%0t: unexpected pixel: expected none, actual %h last %b end %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            want = pending_px.pop_front();
            if (rsp_tdata !== want.px) begin
               $display("%0t: pixel_rgba expected %h actual %h", $time, want.px, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.row_last) begin
               $display("%0t: row_end expected %b actual %b", $time, want.row_last, rsp_tlast);
               errors++;
            end
            if (rsp_tuser !== want.img_last) begin
               $display("%0t: image_end expected %b actual %b", $time, want.img_last, rsp_tuser);
               errors++;
            end
            px_checked++;
            if (want.row_last) rows_seen++;
            if (want.img_last) images_seen++;
         end
      end
   end

   // run ends if nothing moves for too long
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d pixels pending",
                  $time, quiet_cycles, pending_px.size());
         $display("png_scanline_unfilter_top_tb: done, errors");
         $finish;
      end
   end

   initial begin
      int          dir_bytes;
      int          start;
      int          r;
      int          w;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      set_pace(PACE_FULL);
      foreach (DIR_STEPS[i]) begin
         case (DIR_STEPS[i].kind)
            ROW_SET_WIDTH:  write_reg(REG_IMAGE_WIDTH, DIR_STEPS[i].value);
            ROW_SET_HEIGHT: write_reg(REG_IMAGE_HEIGHT, DIR_STEPS[i].value);
            ROW_SET_ALPHA:  write_reg(REG_HAS_ALPHA, DIR_STEPS[i].value);
            default:        send_byte(DIR_STEPS[i].value[7:0], DIR_STEPS[i].known,
                                      DIR_STEPS[i].want);
         endcase
      end
      dir_bytes = bytes_sent;

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         set_pace(pace_type'(ph % 4));
         // width may only move between images, else the line store is stale
         if (row_idx == 0) begin
            r = $urandom_range(99);
            w = (r < 8) ? 0 : (r < 70) ? $urandom_range(6, 1) : $urandom_range(48, 7);
            write_reg(REG_IMAGE_WIDTH, {3'($urandom), 13'(w)});
         end
         write_reg(REG_IMAGE_HEIGHT, rand_height());
         write_reg(REG_HAS_ALPHA, {15'($urandom), 1'($urandom)});
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) begin
            send_row();
            r = $urandom_range(99);
            if (r < 6)       write_reg(REG_IMAGE_HEIGHT, rand_height());
            else if (r < 10) write_reg(REG_HAS_ALPHA, {15'($urandom), 1'($urandom)});
            else if (r < 14) drain();
         end
      end

      drain();
      repeat (END_CYCLES) @(posedge clock);
      $display("%0d bytes sent (%0d from the table), %0d pixels checked, %0d rows, %0d images",
               bytes_sent, dir_bytes, px_checked, rows_seen, images_seen);
      $display("covered rgb and rgba, widths 1 to 48, all filter types, %0d mismatches",
               errors);
      if (errors == 0) begin
         $display("png_scanline_unfilter_top_tb: done, clean");
      end else begin
         $display("png_scanline_unfilter_top_tb: done, errors");
      end
      $finish;
   end

endmodule
